// ----- src/fir101_pkg.sv -----
// Shared constants, types and the coefficient ROM of the 101-tap FIR filter.
// Depends on nothing; every other file but fir101_ram imports it.
package fir101_pkg;

  localparam int TAPS           = 101;
  localparam int COEF_FRAC_BITS = 15;
  localparam int ROM_SIZE       = 101;
  localparam int ROM_FRAC_BITS  = 15;

  localparam int ADDR_W = $clog2(TAPS);
  localparam int COEF_UP = (COEF_FRAC_BITS >= ROM_FRAC_BITS) ?
                           (COEF_FRAC_BITS - ROM_FRAC_BITS) : 0;
  localparam int COEF_DN = (COEF_FRAC_BITS < ROM_FRAC_BITS) ?
                           (ROM_FRAC_BITS - COEF_FRAC_BITS) : 0;
  localparam int COEF_HALF = (1 << COEF_DN) >> 1;
  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 16 + COEF_UP;
  localparam int PROD_W   = SAMPLE_W + COEF_W;
  localparam int ACC_W    = PROD_W + $clog2(TAPS);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [PROD_W-1:0]   prod_t;
  typedef logic signed [ACC_W-1:0]    acc_t;
  typedef logic [ADDR_W-1:0]          addr_t;

  typedef struct packed {
    logic clear;
    logic valid;
  } mac_ctrl_t;

  localparam logic signed [15:0] COEF_ROM [ROM_SIZE] = '{
    -16'sd85, -16'sd166, -16'sd258, -16'sd338, -16'sd379,
    -16'sd365, -16'sd291, -16'sd176, -16'sd53, 16'sd42,
    16'sd78, 16'sd50, -16'sd24, -16'sd103, -16'sd140,
    -16'sd103, 16'sd11, 16'sd169, 16'sd310, 16'sd369,
    16'sd301, 16'sd106, -16'sd167, -16'sd431, -16'sd587,
    -16'sd563, -16'sd341, 16'sd32, 16'sd460, 16'sd827,
    16'sd1043, 16'sd1074, 16'sd959, 16'sd793, 16'sd687,
    16'sd726, 16'sd925, 16'sd1220, 16'sd1488, 16'sd1586,
    16'sd1407, 16'sd927, 16'sd214, -16'sd586, -16'sd1300,
    -16'sd1785, -16'sd1977, -16'sd1912, -16'sd1701, -16'sd1494,
    16'sd31359,
    -16'sd1494, -16'sd1701, -16'sd1912, -16'sd1977, -16'sd1785,
    -16'sd1300, -16'sd586, 16'sd214, 16'sd927, 16'sd1407,
    16'sd1586, 16'sd1488, 16'sd1220, 16'sd925, 16'sd726,
    16'sd687, 16'sd793, 16'sd959, 16'sd1043, 16'sd1074,
    16'sd827, 16'sd460, 16'sd32, -16'sd341, -16'sd563,
    -16'sd587, -16'sd431, -16'sd167, 16'sd106, 16'sd301,
    16'sd369, 16'sd310, 16'sd169, 16'sd11, -16'sd103,
    -16'sd140, -16'sd103, -16'sd24, 16'sd50, 16'sd78,
    16'sd42, -16'sd53, -16'sd176, -16'sd291, -16'sd365,
    -16'sd379, -16'sd338, -16'sd258, -16'sd166, -16'sd85
  };

  // Scale the Q1.15 entry to COEF_FRAC_BITS fractional bits, rounding half up.
  function automatic coef_t coef_at(addr_t k);
    logic signed [31:0] c;
    c = 32'sd0;
    if (int'(k) < ROM_SIZE) begin
      c = 32'(COEF_ROM[k]);
      c = ((c + COEF_HALF) >>> COEF_DN) <<< COEF_UP;
    end
    return coef_t'(c);
  endfunction

endpackage

// ----- src/fir101_ifs.sv -----
// Valid/ready channel interfaces for the FIR filter's sample and result items.
// Depends on fir101_pkg for the payload types.
interface fir101_in_if import fir101_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

interface fir101_out_if import fir101_pkg::*; ();
  logic    valid;
  logic    ready;
  sample_t filtered;
  logic    warm;

  modport source (output valid, output filtered, output warm, input ready);
  modport sink (input valid, input filtered, input warm, output ready);
endinterface

// ----- src/fir101_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module fir101_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 101,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- src/fir101_mac.sv -----
// Shared multiply-accumulate unit: registered product, then wide accumulator.
// Depends on fir101_pkg.
module fir101_mac import fir101_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mac_ctrl_t ctrl,
  input  sample_t   sample,
  input  coef_t     coef,
  output logic      busy,
  output acc_t      acc
);

  prod_t prod_r;
  logic  prod_v_r;
  acc_t  acc_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_v_r <= 1'b0;
    end else begin
      prod_v_r <= ctrl.valid;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= sample * coef;
    if (ctrl.clear) begin
      acc_r <= '0;
    end else if (prod_v_r) begin
      acc_r <= acc_r + {{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r};
    end
  end

  assign busy = prod_v_r;
  assign acc  = acc_r;

endmodule

// ----- src/fir_filter_101_tap_unit.sv -----
// Top level of the 101-tap direct-form FIR filter.
// Depends on fir101_pkg, fir101_ifs, fir101_ram and fir101_mac.
//
// Usage:
//   in_ch  (sink)   : one signed 16-bit sample per item, valid/ready.
//   out_ch (source) : one result item per sample: filtered (rounded,
//                     saturated y[n]) and warm.
//   Each sample is written to a circular history RAM; the sum of
//   h[k] * x[n-k] is then formed by one shared multiplier, one tap per
//   cycle, reading one history entry per cycle from the RAM port.
//   Once warm, each accepted sample passes through ST_RUN, ST_FLUSH,
//   ST_ROUND and ST_HOLD before out_ch.valid; during warm-up it goes
//   straight to ST_HOLD and the item returns filtered = 0, warm = 0.
//   in_ch.ready is high only while no item is in work.
//   A new sample is taken while the last result still waits in the
//   output register.
//   Stall: if out_ch.ready stays low, the finished result waits and the
//   block holds until the output register frees.
//   Reset (rst_n low, synchronous): history marked empty, write slot zero.
//   The first TAPS-1 items are warm-up; the TAPS-th returns the full sum.
module fir_filter_101_tap_unit import fir101_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  fir101_in_if.sink  in_ch,
  fir101_out_if.source out_ch
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_RUN   = 3'd1;
  localparam logic [2:0] ST_FLUSH = 3'd2;
  localparam logic [2:0] ST_ROUND = 3'd3;
  localparam logic [2:0] ST_HOLD  = 3'd4;

  localparam addr_t LAST = addr_t'(TAPS - 1);
  localparam logic signed [ACC_W:0] RND_HALF = (ACC_W+1)'(1 << (COEF_FRAC_BITS - 1));
  localparam logic signed [ACC_W:0] SAT_MAX  = (ACC_W+1)'(32767);
  localparam logic signed [ACC_W:0] SAT_MIN  = -(ACC_W+1)'(32768);

  logic [2:0] state_r, state_nxt;
  addr_t      wp_r, wp_nxt;
  addr_t      rd_addr_r, rd_addr_nxt;
  addr_t      k_r, k_nxt;
  logic       filled_r, filled_nxt;
  logic       iss_v_r, iss_v_nxt;
  coef_t      coef_r, coef_nxt;
  sample_t    res_filt_r, res_filt_nxt;
  logic       res_warm_r, res_warm_nxt;
  logic       out_valid_r, out_valid_nxt;
  sample_t    out_filt_r, out_filt_nxt;
  logic       out_warm_r, out_warm_nxt;

  logic       in_accept;
  logic       ram_we;
  sample_t    ram_q;
  mac_ctrl_t  mac_ctrl;
  logic       mac_busy;
  acc_t       mac_acc;

  logic signed [ACC_W:0] rnd_sum;
  logic signed [ACC_W:0] y_full;
  sample_t               y_sat;

  fir101_ram #(
    .WIDTH (SAMPLE_W),
    .DEPTH (TAPS)
  ) u_hist (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (in_ch.sample),
    .raddr (rd_addr_r),
    .rdata (ram_q)
  );

  fir101_mac u_mac (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (mac_ctrl),
    .sample (ram_q),
    .coef   (coef_r),
    .busy   (mac_busy),
    .acc    (mac_acc)
  );

  always_comb begin
    rnd_sum = {mac_acc[ACC_W-1], mac_acc} + RND_HALF;
    y_full  = rnd_sum >>> COEF_FRAC_BITS;
    if (y_full > SAT_MAX) begin
      y_sat = sample_t'(SAT_MAX);
    end else if (y_full < SAT_MIN) begin
      y_sat = sample_t'(SAT_MIN);
    end else begin
      y_sat = sample_t'(y_full);
    end
  end

  assign in_accept = in_ch.valid && (state_r == ST_IDLE);

  always_comb begin
    state_nxt      = state_r;
    wp_nxt         = wp_r;
    rd_addr_nxt    = rd_addr_r;
    k_nxt          = k_r;
    filled_nxt     = filled_r;
    iss_v_nxt      = 1'b0;
    coef_nxt       = coef_r;
    res_filt_nxt   = res_filt_r;
    res_warm_nxt   = res_warm_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_filt_nxt   = out_filt_r;
    out_warm_nxt   = out_warm_r;
    ram_we         = 1'b0;
    mac_ctrl.clear = 1'b0;
    mac_ctrl.valid = iss_v_r;

    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          ram_we         = 1'b1;
          mac_ctrl.clear = 1'b1;
          filled_nxt     = filled_r || (wp_r == LAST);
          wp_nxt         = (wp_r == LAST) ? '0 : wp_r + addr_t'(1);
          rd_addr_nxt    = wp_r;
          k_nxt          = '0;
          if (filled_nxt) begin
            state_nxt = ST_RUN;
          end else begin
            res_filt_nxt = '0;
            res_warm_nxt = 1'b0;
            state_nxt    = ST_HOLD;
          end
        end
      end
      ST_RUN: begin
        iss_v_nxt   = 1'b1;
        coef_nxt    = coef_at(k_r);
        k_nxt       = k_r + addr_t'(1);
        rd_addr_nxt = (rd_addr_r == '0) ? LAST : rd_addr_r - addr_t'(1);
        if (k_r == LAST) begin
          state_nxt = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!iss_v_r && !mac_busy) begin
          state_nxt = ST_ROUND;
        end
      end
      ST_ROUND: begin
        res_filt_nxt = y_sat;
        res_warm_nxt = 1'b1;
        state_nxt    = ST_HOLD;
      end
      ST_HOLD: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_filt_nxt  = res_filt_r;
          out_warm_nxt  = res_warm_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      wp_r        <= '0;
      filled_r    <= 1'b0;
      iss_v_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      wp_r        <= wp_nxt;
      filled_r    <= filled_nxt;
      iss_v_r     <= iss_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_addr_r  <= rd_addr_nxt;
    k_r        <= k_nxt;
    coef_r     <= coef_nxt;
    res_filt_r <= res_filt_nxt;
    res_warm_r <= res_warm_nxt;
    out_filt_r <= out_filt_nxt;
    out_warm_r <= out_warm_nxt;
  end

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign out_ch.valid    = out_valid_r;
  assign out_ch.filtered = out_filt_r;
  assign out_ch.warm     = out_warm_r;

endmodule

// ----- sim/tb_fir_filter_101_tap_unit.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for fir_filter_101_tap_unit: drives signed samples
// over the valid/ready channel and checks each filtered result against a predictor.
// Depends on fir101_pkg, fir101_ifs and the filter RTL.
module tb_fir_filter_101_tap_unit;
  import fir101_pkg::*;

  localparam int RANDOM_ITEMS = 560;
  localparam int LATENCY      = TAPS + 6;
  localparam int MAX_GAP      = 13;

  typedef struct packed {
    sample_t filtered;
    logic    warm;
  } fir_result_t;

  logic clk;
  logic rst_n;

  fir101_in_if  in_ch ();
  fir101_out_if out_ch ();

  fir_filter_101_tap_unit u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  sample_t     hist [TAPS];
  int          wr_slot   = 0;
  bit          hist_full = 1'b0;
  fir_result_t expected_q [$];

  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;
  int rx_gap  = 0;
  int rx_hold = 0;

  int errors    = 0;
  int n_sent    = 0;
  int n_checked = 0;
  int n_warm    = 0;
  int n_clip_hi = 0;
  int n_clip_lo = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8_000_000;
    $display("%0t: timeout, %0d results still pending", $time, expected_q.size());
    $display("*** FAILED ***");
    $finish;
  end

  function automatic longint tap_weight(input int k);
    longint c;
    if (k >= ROM_SIZE) return 0;
    c = longint'(COEF_ROM[k]);
    return ((c + ((longint'(1) <<< COEF_DN) >>> 1)) >>> COEF_DN) <<< COEF_UP;
  endfunction

  function automatic fir_result_t filter_step(input sample_t x);
    longint      acc;
    longint      y;
    int          k;
    fir_result_t r;
    if (wr_slot >= TAPS) wr_slot = 0;
    hist[wr_slot] = x;
    if (wr_slot == TAPS - 1) hist_full = 1'b1;
    acc = 0;
    y   = 0;
    if (hist_full) begin
      for (k = 0; k < TAPS; k++)
        acc += tap_weight(k) * longint'(hist[(wr_slot + TAPS - k) % TAPS]);
      y = (acc + (longint'(1) <<< (COEF_FRAC_BITS - 1))) >>> COEF_FRAC_BITS;
      if (y > 32767) y = 32767;
      if (y < -32768) y = -32768;
    end
    wr_slot = (wr_slot + 1) % TAPS;
    r.filtered = sample_t'(y);
    r.warm     = hist_full;
    return r;
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance.
  task automatic send_sample(input sample_t s);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_GAP) : 0;
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.sample <= s;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    expected_q.push_back(filter_step(s));
    n_sent++;
    @(negedge clk);
  endtask

  // Line up TAPS samples with the coefficient signs so the last sum clips.
  task automatic send_matched_run(input bit negate, input bit full_scale);
    int     j;
    int     mag;
    bit     pos;
    for (j = 0; j < TAPS; j++) begin
      mag = full_scale ? 32767 : $urandom_range(20000, 32767);
      pos = (tap_weight(TAPS - 1 - j) >= 0) ^ negate;
      send_sample(pos ? sample_t'(mag) : sample_t'(-mag - 1));
    end
  endtask

  always @(posedge clk) begin
    fir_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_q.size() == 0) begin
        $display("%0t: result with nothing expected, actual filtered=%0d warm=%0b",
                 $time, out_ch.filtered, out_ch.warm);
        errors++;
      end else begin
        want = expected_q.pop_front();
        if (out_ch.filtered !== want.filtered) begin
          $display("%0t: filtered mismatch, expected %0d, actual %0d",
                   $time, want.filtered, out_ch.filtered);
          errors++;
        end
        if (out_ch.warm !== want.warm) begin
          $display("%0t: warm mismatch, expected %0b, actual %0b",
                   $time, want.warm, out_ch.warm);
          errors++;
        end
        n_checked++;
        if (want.warm) n_warm++;
        if (want.warm && want.filtered == 16'sh7fff) n_clip_hi++;
        if (want.warm && want.filtered == -16'sh8000) n_clip_lo++;
      end
      rx_gap = rx_idle ? $urandom_range(0, MAX_GAP) : 0;
    end
  end

  initial begin : receiver
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(negedge clk);
      if (rx_hold > 0) begin
        out_ch.ready <= 1'b0;
        rx_hold--;
      end else if (rx_gap > 0) begin
        out_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  task automatic test_warmup();
    int i;
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_sample(16'sh7fff);
    send_sample(-16'sh8000);
    send_sample(16'sh5555);
    send_sample(-16'sh5556);
    send_sample(16'sh0000);
    send_sample(-16'sh0001);
    for (i = 6; i < TAPS; i++)
      send_sample(sample_t'($urandom));
  endtask

  task automatic test_extremes();
    sample_t vals [20];
    vals = '{16'sh7fff, -16'sh8000, 16'sh0000, -16'sh0001, 16'sh0001, -16'sh0002,
             16'sh4000, -16'sh4000, 16'sh5555, -16'sh5556, 16'sh7fff, 16'sh7fff,
             16'sh7fff, -16'sh8000, -16'sh8000, -16'sh8000, 16'sh0000, 16'sh0000,
             16'sh0000, 16'sh0001};
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    foreach (vals[i]) send_sample(vals[i]);
  endtask

  task automatic test_clipping();
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    send_matched_run(1'b0, 1'b1);
    send_matched_run(1'b1, 1'b1);
  endtask

  task automatic test_random();
    int count;
    int mode;
    int len;
    int i;
    count = 0;
    while (count < RANDOM_ITEMS) begin
      mode    = $urandom_range(0, 4);
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      if (mode == 4) begin
        send_matched_run(1'($urandom_range(0, 1)), 1'b0);
        count += TAPS;
      end else begin
        len = $urandom_range(20, 60);
        for (i = 0; i < len; i++) begin
          case (mode)
            0: send_sample(sample_t'($urandom));
            1: send_sample(sample_t'($urandom_range(0, 511) - 256));
            2: case ($urandom_range(0, 3))
                 0: send_sample(16'sh7fff);
                 1: send_sample(-16'sh8000);
                 2: send_sample(16'sh0000);
                 default: send_sample(-16'sh0001);
               endcase
            default: send_sample(sample_t'($urandom_range(0, 8191) - 4096));
          endcase
        end
        count += len;
      end
    end
  endtask

  // Hold the result side off while items keep coming, so the input stalls.
  task automatic test_backpressure();
    int i;
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    in_ch.valid <= 1'b0;
    @(posedge clk);
    rx_hold = 8 * LATENCY;
    @(negedge clk);
    for (i = 0; i < 10; i++)
      send_sample(sample_t'($urandom));
    rx_idle = 1'b1;
  endtask

  initial begin
    int drain;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.sample = '0;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_warmup();
    test_extremes();
    test_clipping();
    test_random();
    test_backpressure();

    in_ch.valid <= 1'b0;
    drain = 0;
    while (expected_q.size() != 0 && drain < 20 * LATENCY + 16 * MAX_GAP) begin
      @(negedge clk);
      drain++;
    end
    if (expected_q.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, expected_q.size());
      errors++;
    end
    repeat (2 * LATENCY) @(negedge clk);

    $display("Run: %0d samples in, %0d results checked, %0d after warm-up",
             n_sent, n_checked, n_warm);
    $display("Clipping seen: %0d at the positive limit, %0d at the negative limit",
             n_clip_hi, n_clip_lo);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("%0d mismatches", errors);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
